// ----- design/assert_macros.svh -----
// Assertion macros used by the allocator design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies a property in the same cycle.
`define BBA_ASSERT_NOW(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// Check that a condition implies a property in the following cycle.
`define BBA_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ----- design/bba_pkg.sv -----
// Shared types and constants of the buddy block allocator.
package bba_pkg;

  localparam int LEAF_LEVELS = 7;
  localparam int MIN_BLOCK   = 8;
  localparam int MIN_SHIFT   = 3;
  localparam int LEAF_COUNT  = 1 << LEAF_LEVELS;
  localparam int NODE_COUNT  = (2 << LEAF_LEVELS) - 1;
  localparam int POOL_BYTES  = MIN_BLOCK << LEAF_LEVELS;

  localparam int NODE_W  = LEAF_LEVELS + 1;
  localparam int CNT_W   = LEAF_LEVELS + MIN_SHIFT + 1;
  localparam int LVL_W   = $clog2(LEAF_LEVELS + 1);
  localparam int OFF_W   = 7;
  localparam int SIZE_W  = 12;
  localparam int STAT_W  = 2;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE    = 2'd0,
    STAT_NOROOM  = 2'd1,
    STAT_NOBLOCK = 2'd2
  } status_t;

  // One tree node: allocated mark and bytes in use below it.
  typedef struct packed {
    logic             alloc;
    logic [CNT_W-1:0] used;
  } node_t;

endpackage

// ----- design/bba_in_if.sv -----
// Request channel of the buddy block allocator.
interface bba_in_if;
  import bba_pkg::*;

  logic              valid;
  logic              ready;
  logic              mode;
  logic [SIZE_W-1:0] size_bytes;
  logic [OFF_W-1:0]  word_offset;

  modport source (output valid, output mode, output size_bytes, output word_offset,
                  input ready);
  modport sink   (input valid, input mode, input size_bytes, input word_offset,
                  output ready);
endinterface

// ----- design/bba_out_if.sv -----
// Result channel of the buddy block allocator.
interface bba_out_if;
  import bba_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [OFF_W-1:0]  block_offset;

  modport source (output valid, output status, output block_offset, input ready);
  modport sink   (input valid, input status, input block_offset, output ready);
endinterface

// ----- design/buddy_block_allocator.sv -----
// Buddy block allocator. Allocate: steps down the tree one level at a time (up to 8 levels),
// then on a failed descent walks back up through each ancestor for the rollback. Free:
// walks one level at a time from leaf to root (8 levels).
// The node memory does one read-modify-write per cycle, so one item is in work at a time:
// the next item is accepted the cycle after its result loads.
// Synchronous reset clears control state and the node valid bits, so all counts read 0.
`include "assert_macros.svh"

module buddy_block_allocator (
  input logic        clk,
  input logic        rst_n,
  bba_in_if.sink     in_ch,
  bba_out_if.source  out_ch
);
  import bba_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DOWN = 5'b00010,
    ST_UNDO = 5'b00100,
    ST_FREE = 5'b01000,
    ST_WAIT = 5'b10000
  } state_t;

  // Node memory, two read ports and one write port
  node_t                 mem [NODE_COUNT];
  logic [NODE_COUNT-1:0] vld_r;
  node_t                 rd_a_r, rd_b_r;
  logic                  rd_a_v_r, rd_b_v_r;
  logic [NODE_W-1:0]     addr_a, addr_b;
  logic                  rd_req;
  logic                  mem_we;
  logic [NODE_W-1:0]     mem_wa;
  node_t                 mem_wd;

  // Control and item registers
  state_t            state_r, state_nxt;
  logic [NODE_W-1:0] node_a_r, node_a_nxt;
  logic [NODE_W-1:0] node_b_r, node_b_nxt;
  logic [LVL_W-1:0]  depth_r, depth_nxt;
  logic [CNT_W-1:0]  sz_r, sz_nxt;
  logic              big_r, big_nxt;
  logic [OFF_W-1:0]  off_r, off_nxt;
  logic              found_r, found_nxt;
  logic [STAT_W-1:0] res_status_r, res_status_nxt;
  logic [OFF_W-1:0]  res_off_r, res_off_nxt;
  logic              out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic [OFF_W-1:0]  out_off_r;

  // Datapath helpers
  node_t             ent_a, ent_b, ent;
  logic              pick_b;
  logic [NODE_W-1:0] node_cur, node_par;
  logic [CNT_W:0]    sum;
  logic [CNT_W-1:0]  block;
  logic              no_room, term;
  logic [OFF_W-1:0]  off_cur;
  logic [CNT_W-1:0]  rsz;
  logic              rbig;
  logic              hit;
  logic [CNT_W-1:0]  amt;
  logic              fin;
  logic [STAT_W-1:0] fin_status;
  logic [OFF_W-1:0]  fin_off;
  logic              out_free, out_load;
  logic              in_acc;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.block_offset = out_off_r;
  assign out_free = !out_valid_r || out_ch.ready;

  // Round the request up to a power of two, at least the minimum block
  always_comb begin
    rsz  = '0;
    rbig = 1'b1;
    for (int k = LEAF_LEVELS + MIN_SHIFT; k >= MIN_SHIFT; k--) begin
      if ({1'b0, in_ch.size_bytes} <= (13'(1) << k)) begin
        rsz  = CNT_W'(1) << k;
        rbig = 1'b0;
      end
    end
  end

  // Entries that were never written read as zero
  assign ent_a = rd_a_v_r ? rd_a_r : '0;
  assign ent_b = rd_b_v_r ? rd_b_r : '0;

  // Descent: take the less-used child, ties go left
  assign pick_b   = ent_a.used > ent_b.used;
  assign node_cur = pick_b ? node_b_r : node_a_r;
  assign ent      = (state_r == ST_DOWN) ? (pick_b ? ent_b : ent_a) : ent_a;
  assign node_par = (node_cur - NODE_W'(1)) >> 1;
  assign sum      = {1'b0, ent.used} + {1'b0, sz_r};
  assign block    = CNT_W'(POOL_BYTES) >> depth_r;
  assign no_room  = big_r || (sum > {1'b0, block});
  assign term     = (sz_r == block) || (depth_r == LVL_W'(LEAF_LEVELS));
  assign off_cur  = pick_b ? off_r + (OFF_W'(1) << (LVL_W'(LEAF_LEVELS) - depth_r)) : off_r;

  // Free walk: first allocated mark on the way up sets the amount
  assign hit = !found_r && ent_a.alloc;
  assign amt = hit ? (CNT_W'(MIN_BLOCK) << depth_r) : sz_r;

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    node_a_nxt     = node_a_r;
    node_b_nxt     = node_b_r;
    depth_nxt      = depth_r;
    sz_nxt         = sz_r;
    big_nxt        = big_r;
    off_nxt        = off_r;
    found_nxt      = found_r;
    res_status_nxt = res_status_r;
    res_off_nxt    = res_off_r;
    addr_a         = node_a_r;
    addr_b         = node_b_r;
    rd_req         = 1'b0;
    mem_we         = 1'b0;
    mem_wa         = node_cur;
    mem_wd         = ent;
    fin            = 1'b0;
    fin_status     = STAT_DONE;
    fin_off        = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          rd_req    = 1'b1;
          depth_nxt = '0;
          off_nxt   = '0;
          found_nxt = 1'b0;
          if (in_ch.mode == MODE_ALLOC) begin
            addr_a     = '0;
            addr_b     = '0;
            node_a_nxt = '0;
            node_b_nxt = '0;
            sz_nxt     = rsz;
            big_nxt    = rbig;
            state_nxt  = ST_DOWN;
          end else begin
            addr_a     = NODE_W'(in_ch.word_offset) + NODE_W'(LEAF_COUNT - 1);
            node_a_nxt = addr_a;
            // Park the spare read port on the root, written only on the last step
            node_b_nxt = '0;
            big_nxt    = 1'b0;
            state_nxt  = ST_FREE;
          end
        end
      end
      ST_DOWN: begin
        if (no_room) begin
          if (node_cur == '0) begin
            fin        = 1'b1;
            fin_status = STAT_NOROOM;
          end else begin
            rd_req     = 1'b1;
            addr_a     = node_par;
            node_a_nxt = node_par;
            state_nxt  = ST_UNDO;
          end
        end else begin
          mem_we       = 1'b1;
          mem_wd.used  = sum[CNT_W-1:0];
          mem_wd.alloc = ent.alloc | term;
          if (term) begin
            fin     = 1'b1;
            fin_off = off_cur;
          end else begin
            rd_req     = 1'b1;
            addr_a     = {node_cur[NODE_W-2:0], 1'b1};
            addr_b     = {node_cur[NODE_W-2:0], 1'b0} + NODE_W'(2);
            node_a_nxt = addr_a;
            node_b_nxt = addr_b;
            depth_nxt  = depth_r + LVL_W'(1);
            off_nxt    = off_cur;
          end
        end
      end
      ST_UNDO: begin
        // Take the request back out of each ancestor
        mem_we      = 1'b1;
        mem_wa      = node_a_r;
        mem_wd      = ent_a;
        mem_wd.used = (ent_a.used > sz_r) ? ent_a.used - sz_r : '0;
        if (node_a_r == '0) begin
          fin        = 1'b1;
          fin_status = STAT_NOROOM;
        end else begin
          rd_req     = 1'b1;
          addr_a     = (node_a_r - NODE_W'(1)) >> 1;
          node_a_nxt = addr_a;
        end
      end
      ST_FREE: begin
        mem_wa      = node_a_r;
        mem_wd      = ent_a;
        mem_we      = found_r || hit;
        mem_wd.alloc = hit ? 1'b0 : ent_a.alloc;
        mem_wd.used  = (ent_a.used > amt) ? ent_a.used - amt : '0;
        found_nxt   = found_r || hit;
        sz_nxt      = amt;
        if (node_a_r == '0) begin
          fin        = 1'b1;
          fin_status = (found_r || hit) ? STAT_DONE : STAT_NOBLOCK;
        end else begin
          rd_req     = 1'b1;
          addr_a     = (node_a_r - NODE_W'(1)) >> 1;
          node_a_nxt = addr_a;
          depth_nxt  = depth_r + LVL_W'(1);
        end
      end
      ST_WAIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    // Hand the result to the output register or park it
    if (fin) begin
      res_status_nxt = fin_status;
      res_off_nxt    = fin_off;
      state_nxt      = out_free ? ST_IDLE : ST_WAIT;
    end
  end

  assign out_load = out_free && (fin || (state_r == ST_WAIT));

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item and result registers
  always_ff @(posedge clk) begin
    node_a_r     <= node_a_nxt;
    node_b_r     <= node_b_nxt;
    depth_r      <= depth_nxt;
    sz_r         <= sz_nxt;
    big_r        <= big_nxt;
    off_r        <= off_nxt;
    found_r      <= found_nxt;
    res_status_r <= res_status_nxt;
    res_off_r    <= res_off_nxt;
    if (out_load) begin
      out_status_r <= fin ? fin_status : res_status_r;
      out_off_r    <= fin ? fin_off : res_off_r;
    end
  end

  // Node valid bits, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (mem_we) begin
      vld_r[mem_wa] <= 1'b1;
    end
  end

  // Node memory with registered reads
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_a_r   <= mem[addr_a];
    rd_b_r   <= mem[addr_b];
    rd_a_v_r <= vld_r[addr_a];
    rd_b_v_r <= vld_r[addr_b];
  end

  `BBA_ASSERT_NOW(a_no_rw_clash, mem_we && rd_req, (mem_wa != addr_a) && (mem_wa != addr_b), "node read and write hit the same entry")
  `BBA_ASSERT_NOW(a_sibling_pair, (state_r == ST_DOWN) && (depth_r != '0), node_b_r == node_a_r + NODE_W'(1), "descent candidates are not siblings")
  `BBA_ASSERT_NEXT(a_busy_after_accept, in_acc, state_r != ST_IDLE, "accepted item did not start")

endmodule

// ----- verif/buddy_block_allocator_test.sv -----
// Self-checking testbench for the buddy block allocator: directed table plus random traffic.
module buddy_block_allocator_test;
  import bba_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 1000;
  localparam int NUM_DIRECTED = 25;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS  = 10;

  // One result item of the allocator
  typedef struct {
    status_t          status;
    logic [OFF_W-1:0] block_offset;
  } alloc_result_t;

  // One row of the directed table; exact rows carry a hand-written result
  typedef struct {
    logic             mode;
    int unsigned      size;
    int unsigned      woff;
    bit               exact;
    status_t          status;
    logic [OFF_W-1:0] block_offset;
  } table_row_t;

  // A block currently held, in 64-bit words
  typedef struct {
    int unsigned offset;
    int unsigned words;
  } live_block_t;

  logic clk = 1'b0;
  logic rst_n;
  bit   sink_ready;
  bit   steady_phase;
  int   cycle_count;
  int   error_count;

  // Tree shadow: bytes in use per node and allocated marks
  int unsigned   tree_used [NODE_COUNT];
  bit            tree_marked [NODE_COUNT];
  live_block_t   live_blocks[$];
  alloc_result_t expected_results[$];
  table_row_t    directed_rows [NUM_DIRECTED];

  bba_in_if  in_ch();
  bba_out_if out_ch();

  buddy_block_allocator u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #10 clk = ~clk;

  assign out_ch.ready = sink_ready;

  // Stall the result side at random, except in the steady stretch
  always @(posedge clk) begin
    sink_ready <= steady_phase || ($urandom_range(0, 99) >= 25);
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Take bytes off a node count, saturating at zero
  function automatic void release_bytes(int unsigned node, int unsigned amount);
    tree_used[node] = (tree_used[node] > amount) ? tree_used[node] - amount : 0;
  endfunction

  // Work out the result of one request and advance the tree shadow
  function automatic alloc_result_t predict_request(logic mode, int unsigned size,
                                                    int unsigned woff);
    alloc_result_t res;
    int unsigned   sz;
    int unsigned   node;
    int unsigned   depth;
    int unsigned   off;
    int unsigned   blk;
    int unsigned   lchild;
    bit            finished;
    bit            found;
    live_block_t   blk_rec;

    res.status       = STAT_DONE;
    res.block_offset = '0;
    if (mode == MODE_ALLOC) begin
      sz = MIN_BLOCK;
      while (sz < size) sz = sz << 1;
      node     = 0;
      depth    = 0;
      off      = 0;
      blk      = POOL_BYTES;
      finished = 1'b0;
      while (!finished) begin
        if (tree_used[node] + sz > blk) begin
          // roll back the counts added on the way down
          while (node != 0) begin
            node = (node - 1) >> 1;
            release_bytes(node, sz);
          end
          res.status = STAT_NOROOM;
          finished   = 1'b1;
        end else begin
          tree_used[node] += sz;
          if (sz == blk || depth >= LEAF_LEVELS) begin
            tree_marked[node]  = 1'b1;
            res.block_offset   = off[OFF_W-1:0];
            blk_rec.offset     = off;
            blk_rec.words      = sz / MIN_BLOCK;
            live_blocks.push_back(blk_rec);
            finished           = 1'b1;
          end else begin
            // descend into the less-used child, ties go left
            lchild = 2 * node + 1;
            if (tree_used[lchild] <= tree_used[lchild + 1]) begin
              node = lchild;
            end else begin
              node = lchild + 1;
              off  = off + ((LEAF_COUNT >> 1) >> depth);
            end
            depth++;
            blk = blk >> 1;
          end
        end
      end
    end else begin
      node  = woff + LEAF_COUNT - 1;
      depth = 0;
      sz    = 0;
      found = 1'b0;
      finished = 1'b0;
      // walk leaf to root, clear the first mark and drain its bytes upward
      while (!finished) begin
        if (!found && tree_marked[node]) begin
          tree_marked[node] = 1'b0;
          sz    = MIN_BLOCK << depth;
          found = 1'b1;
        end
        if (found) release_bytes(node, sz);
        if (node == 0) begin
          finished = 1'b1;
        end else begin
          node = (node - 1) >> 1;
          depth++;
        end
      end
      if (found) begin
        for (int i = 0; i < live_blocks.size(); i++) begin
          if (woff >= live_blocks[i].offset &&
              woff < live_blocks[i].offset + live_blocks[i].words) begin
            live_blocks.delete(i);
            break;
          end
        end
      end else begin
        res.status = STAT_NOBLOCK;
      end
    end
    return res;
  endfunction

  // Offer one item, hold it until accepted and queue its expected result
  task automatic send_request(logic mode, int unsigned size, int unsigned woff,
                              bit exact, alloc_result_t typed);
    alloc_result_t predicted;

    if (!steady_phase && $urandom_range(0, 99) < 25) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 25);
    end
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= mode;
    in_ch.size_bytes  <= size[SIZE_W-1:0];
    in_ch.word_offset <= woff[OFF_W-1:0];
    do @(negedge clk); while (!in_ch.ready);
    predicted = predict_request(mode, size, woff);
    expected_results.push_back(exact ? typed : predicted);
    @(posedge clk);
  endtask

  // Compare each result item against the oldest expectation
  always @(negedge clk) begin
    alloc_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("unexpected result: status %0d offset %0d",
                   out_ch.status, out_ch.block_offset);
      end else begin
        want = expected_results.pop_front();
        if (out_ch.status !== want.status || out_ch.block_offset !== want.block_offset) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("result mismatch: expected status %0d offset %0d, got %0d offset %0d",
                     want.status, want.block_offset, out_ch.status, out_ch.block_offset);
        end
      end
    end
  end

  initial begin
    alloc_result_t typed;
    logic          mode;
    int unsigned   size;
    int unsigned   woff;
    int unsigned   pick;

    in_ch.valid       <= 1'b0;
    in_ch.mode        <= MODE_ALLOC;
    in_ch.size_bytes  <= '0;
    in_ch.word_offset <= '0;
    rst_n             <= 1'b0;
    steady_phase       = 1'b0;
    cycle_count        = 0;
    error_count        = 0;
    foreach (tree_used[i]) begin
      tree_used[i]   = 0;
      tree_marked[i] = 1'b0;
    end

    // extremes, error codes and a mixed fill; exact rows are hand-checked
    directed_rows = '{
      '{MODE_ALLOC,    0, 127, 1'b1, STAT_DONE,    7'd0},  // zero size is 8 bytes
      '{MODE_FREE,  4095,   0, 1'b1, STAT_DONE,    7'd0},
      '{MODE_FREE,     0,   0, 1'b1, STAT_NOBLOCK, 7'd0},  // double free
      '{MODE_ALLOC, 4095,   0, 1'b1, STAT_NOROOM,  7'd0},  // oversized
      '{MODE_ALLOC, 1025,   0, 1'b1, STAT_NOROOM,  7'd0},
      '{MODE_ALLOC, 1024,  85, 1'b1, STAT_DONE,    7'd0},  // whole pool
      '{MODE_ALLOC,    8,   0, 1'b1, STAT_NOROOM,  7'd0},  // full at root
      '{MODE_FREE,     0, 127, 1'b1, STAT_DONE,    7'd0},  // free inside the pool block
      '{MODE_FREE,     0,  64, 1'b1, STAT_NOBLOCK, 7'd0},
      '{MODE_ALLOC,    1,   0, 1'b0, STAT_DONE,    7'd0},
      '{MODE_ALLOC,    8,   0, 1'b0, STAT_DONE,    7'd0},
      '{MODE_ALLOC,    9,   0, 1'b0, STAT_DONE,    7'd0},
      '{MODE_ALLOC,  512,   0, 1'b0, STAT_DONE,    7'd0},
      '{MODE_ALLOC,  513,   0, 1'b0, STAT_DONE,    7'd0},
      '{MODE_ALLOC,  256,   0, 1'b0, STAT_DONE,    7'd0},
      '{MODE_ALLOC,   65,   0, 1'b0, STAT_DONE,    7'd0},
      '{MODE_ALLOC,  129,   0, 1'b0, STAT_DONE,    7'd0},
      '{MODE_ALLOC,   33,   0, 1'b0, STAT_DONE,    7'd0},
      '{MODE_ALLOC,   17,   0, 1'b0, STAT_DONE,    7'd0},
      '{MODE_FREE,     0,  65, 1'b0, STAT_DONE,    7'd0},
      '{MODE_FREE,  2730,   0, 1'b0, STAT_DONE,    7'd0},
      '{MODE_FREE,     0, 127, 1'b0, STAT_DONE,    7'd0},
      '{MODE_ALLOC, 1000,   0, 1'b0, STAT_DONE,    7'd0},
      '{MODE_FREE,     0,   3, 1'b0, STAT_DONE,    7'd0},
      '{MODE_ALLOC, 2048,  42, 1'b0, STAT_DONE,    7'd0}
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // walk the directed table
    foreach (directed_rows[i]) begin
      typed.status       = directed_rows[i].status;
      typed.block_offset = directed_rows[i].block_offset;
      send_request(directed_rows[i].mode, directed_rows[i].size, directed_rows[i].woff,
                   directed_rows[i].exact, typed);
    end

    // random traffic: mostly allocations and frees of held blocks, some noise
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady_phase = (n >= 400 && n < 600);
      size = $urandom_range(0, 4095);
      woff = $urandom_range(0, 127);
      pick = $urandom_range(0, 99);
      if (live_blocks.size() == 0 || pick < 55) begin
        mode = MODE_ALLOC;
        pick = $urandom_range(0, 99);
        if (pick < 65)      size = $urandom_range(0, 64);
        else if (pick < 90) size = $urandom_range(65, 1024);
      end else begin
        mode = MODE_FREE;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          woff = live_blocks[$urandom_range(0, live_blocks.size() - 1)].offset;
        end else if (pick < 85) begin
          pick = $urandom_range(0, live_blocks.size() - 1);
          woff = live_blocks[pick].offset + $urandom_range(0, live_blocks[pick].words - 1);
        end
      end
      send_request(mode, size, woff, 1'b0, typed);
    end
    steady_phase = 1'b0;
    in_ch.valid <= 1'b0;

    // drain outstanding results, then let the block settle
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
